FILE: hdl/cft_pkg.sv
// package for the composite format tokenizer
// types, character codes, result kinds and queue sizing; no dependencies
`default_nettype none

package cft_pkg;

    localparam int MaxChars = 65536;
    localparam int PosW     = $clog2(MaxChars + 1);
    localparam int CharW    = 16;
    localparam int FieldW   = 16;
    localparam int KindW    = 3;
    localparam int QDepth   = 4;
    localparam int QAw      = $clog2(QDepth);

    localparam logic [CharW-1:0] ChNul    = 16'h0000;
    localparam logic [CharW-1:0] ChSpace  = 16'h0020;
    localparam logic [CharW-1:0] ChZero   = 16'h0030;
    localparam logic [CharW-1:0] ChNine   = 16'h0039;
    localparam logic [CharW-1:0] ChColon  = 16'h003A;
    localparam logic [CharW-1:0] ChLbrace = 16'h007B;
    localparam logic [CharW-1:0] ChRbrace = 16'h007D;

    localparam logic [FieldW+3:0] IndexMax = 20'd65535;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_OPEN,
        MODE_INDEX,
        MODE_FORMAT
    } t_mode;

    typedef enum logic [KindW-1:0] {
        KIND_LITERAL,
        KIND_ARGUMENT,
        KIND_END,
        KIND_INVALID,
        KIND_LIMIT,
        KIND_LONG
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [FieldW-1:0] span_start;
        logic [FieldW-1:0] span_length;
        logic [FieldW-1:0] arg_index;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    item0;
        t_result    item1;
    } t_push;

    function automatic t_result mk_result(
        input t_kind             kind,
        input logic [FieldW-1:0] start,
        input logic [FieldW-1:0] len,
        input logic [FieldW-1:0] idx,
        input logic              last
    );
        t_result r;
        r.kind        = kind;
        r.span_start  = start;
        r.span_length = len;
        r.arg_index   = idx;
        r.last        = last;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/cft_if.sv
// valid/ready channel interfaces for characters in and result items out
// depends on cft_pkg
`default_nettype none

interface cft_char_if import cft_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface cft_result_if import cft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KindW-1:0]  kind;
    logic [FieldW-1:0] span_start;
    logic [FieldW-1:0] span_length;
    logic [FieldW-1:0] arg_index;
    logic              last;

    modport source (output valid, output kind, output span_start, output span_length,
                    output arg_index, output last, input ready);
    modport sink   (input valid, input kind, input span_start, input span_length,
                    input arg_index, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/composite_format_tokenizer_core.sv
// top level of the composite format tokenizer: front parser, result queue, output stage
// depends on cft_pkg, cft_if, cft_front, cft_queue, cft_back
//
// channel    dir  handshake     payload
// i_char     in   valid/ready   character[15:0]
// o_result   out  valid/ready   kind[2:0] span_start span_length arg_index last
//
// one character a cycle while the queue has room; the parse state updates in the cycle it is taken
// a result reaches the output through the queue, then the output register
// a terminator after pending text gives two items, sent one a cycle while the output is ready
// input stalls only while the 4-entry queue holds more than two items
// reset is synchronous, active low, and clears parse state, queue and output valid
`default_nettype none

module composite_format_tokenizer_core
    import cft_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    cft_char_if.sink     i_char,
    cft_result_if.source o_result
);

    t_push   w_push;
    logic    w_q_ready;
    logic    w_q_valid;
    t_result w_head;
    logic    w_pop;

    cft_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_char    (i_char),
        .i_q_ready (w_q_ready),
        .o_push    (w_push)
    );

    cft_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .o_q_ready (w_q_ready),
        .o_q_valid (w_q_valid),
        .o_head    (w_head),
        .i_pop     (w_pop)
    );

    cft_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_head    (w_head),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );

    a_two_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.n == 2'd2) |-> (w_push.item0.kind == KIND_LITERAL &&
                                w_push.item1.kind == KIND_END))
        else $error("double push is not literal then end");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.n != 2'd0) |-> w_q_ready)
        else $error("push into a queue without room");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.last ==
            (o_result.kind != KIND_LITERAL && o_result.kind != KIND_ARGUMENT)))
        else $error("last flag does not match item kind");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: hdl/cft_front.sv
// front part: accepts characters, runs the parse state and pushes up to two results
// depends on cft_pkg and cft_if
`default_nettype none

module cft_front
    import cft_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cft_char_if.sink   i_char,
    input  wire logic  i_q_ready,
    output t_push      o_push
);

    t_mode             r_mode, n_mode;
    logic [PosW-1:0]   r_position, n_position;
    logic [FieldW-1:0] r_lit_start, n_lit_start;
    logic [FieldW-1:0] r_brace_pos, n_brace_pos;
    logic [FieldW-1:0] r_index, n_index;
    logic [FieldW-1:0] r_fmt_start, n_fmt_start;
    logic              r_discarding, n_discarding;

    logic              w_acc;
    logic [CharW-1:0]  w_ch;
    logic [FieldW-1:0] w_pos;
    logic [FieldW-1:0] w_pos_inc;
    logic              w_is_digit;
    logic [3:0]        w_digit;
    logic [FieldW+3:0] w_index_next;
    logic              w_restart;
    logic              w_advance;

    assign i_char.ready = i_q_ready;
    assign w_acc        = i_char.valid && i_q_ready;
    assign w_ch         = i_char.character;
    assign w_pos        = r_position[FieldW-1:0];
    assign w_pos_inc    = w_pos + FieldW'(1);
    assign w_is_digit   = (w_ch >= ChZero) && (w_ch <= ChNine);
    assign w_digit      = w_ch[3:0];
    // index times ten plus digit
    assign w_index_next = {1'b0, r_index, 3'b000} + {3'b000, r_index, 1'b0}
                        + {16'h0000, w_digit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_TEXT;
            r_position   <= '0;
            r_lit_start  <= '0;
            r_brace_pos  <= '0;
            r_index      <= '0;
            r_fmt_start  <= '0;
            r_discarding <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_position   <= n_position;
            r_lit_start  <= n_lit_start;
            r_brace_pos  <= n_brace_pos;
            r_index      <= n_index;
            r_fmt_start  <= n_fmt_start;
            r_discarding <= n_discarding;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_position   = r_position;
        n_lit_start  = r_lit_start;
        n_brace_pos  = r_brace_pos;
        n_index      = r_index;
        n_fmt_start  = r_fmt_start;
        n_discarding = r_discarding;
        o_push.n     = 2'd0;
        o_push.item0 = mk_result(KIND_LITERAL, '0, '0, '0, 1'b0);
        o_push.item1 = mk_result(KIND_END, '0, '0, '0, 1'b1);
        w_restart    = 1'b0;
        w_advance    = 1'b0;

        if (w_acc) begin
            if (r_discarding) begin
                w_restart = (w_ch == ChNul);
            end else if (r_position >= PosW'(MaxChars)) begin
                o_push.n     = 2'd1;
                o_push.item0 = mk_result(KIND_LONG, '0, '0, '0, 1'b1);
                w_restart    = (w_ch == ChNul);
                n_discarding = (w_ch != ChNul);
            end else begin
                w_advance = 1'b1;
                unique case (r_mode)
                    MODE_TEXT: begin
                        if (w_ch == ChLbrace) begin
                            n_brace_pos = w_pos;
                            n_index     = '0;
                            n_mode      = MODE_OPEN;
                        end else if (w_ch == ChNul) begin
                            w_advance = 1'b0;
                            w_restart = 1'b1;
                            if (w_pos > r_lit_start) begin
                                o_push.n     = 2'd2;
                                o_push.item0 = mk_result(KIND_LITERAL, r_lit_start,
                                                         w_pos - r_lit_start, '0, 1'b0);
                                o_push.item1 = mk_result(KIND_END, w_pos, '0, '0, 1'b1);
                            end else begin
                                o_push.n     = 2'd1;
                                o_push.item0 = mk_result(KIND_END, w_pos, '0, '0, 1'b1);
                            end
                        end
                    end
                    MODE_OPEN: begin
                        if (w_is_digit) begin
                            if (r_brace_pos > r_lit_start) begin
                                o_push.n     = 2'd1;
                                o_push.item0 = mk_result(KIND_LITERAL, r_lit_start,
                                                         r_brace_pos - r_lit_start, '0, 1'b0);
                            end
                            n_index = {12'h000, w_digit};
                            n_mode  = MODE_INDEX;
                        end else if (w_ch == ChLbrace) begin
                            o_push.n     = 2'd1;
                            o_push.item0 = mk_result(KIND_LITERAL, r_lit_start,
                                                     w_pos - r_lit_start, '0, 1'b0);
                            n_lit_start  = w_pos_inc;
                            n_mode       = MODE_TEXT;
                        end else if (w_ch != ChSpace) begin
                            w_advance    = 1'b0;
                            o_push.n     = 2'd1;
                            o_push.item0 = mk_result(KIND_INVALID, w_pos, '0, '0, 1'b1);
                            w_restart    = (w_ch == ChNul);
                            n_discarding = (w_ch != ChNul);
                        end
                    end
                    MODE_INDEX: begin
                        if (w_is_digit) begin
                            if (w_index_next > IndexMax) begin
                                w_advance    = 1'b0;
                                o_push.n     = 2'd1;
                                o_push.item0 = mk_result(KIND_LIMIT, w_pos, '0, '0, 1'b1);
                                n_discarding = 1'b1;
                            end else begin
                                n_index = w_index_next[FieldW-1:0];
                            end
                        end else if (w_ch == ChColon) begin
                            n_fmt_start = w_pos_inc;
                            n_mode      = MODE_FORMAT;
                        end else if (w_ch == ChRbrace) begin
                            o_push.n     = 2'd1;
                            o_push.item0 = mk_result(KIND_ARGUMENT, '0, '0, r_index, 1'b0);
                            n_lit_start  = w_pos_inc;
                            n_mode       = MODE_TEXT;
                        end else begin
                            w_advance    = 1'b0;
                            o_push.n     = 2'd1;
                            o_push.item0 = mk_result(KIND_INVALID, w_pos, '0, '0, 1'b1);
                            w_restart    = (w_ch == ChNul);
                            n_discarding = (w_ch != ChNul);
                        end
                    end
                    MODE_FORMAT: begin
                        if (w_ch == ChRbrace) begin
                            o_push.n     = 2'd1;
                            o_push.item0 = mk_result(KIND_ARGUMENT, r_fmt_start,
                                                     w_pos - r_fmt_start, r_index, 1'b0);
                            n_lit_start  = w_pos_inc;
                            n_mode       = MODE_TEXT;
                        end else if (w_ch == ChNul) begin
                            w_advance    = 1'b0;
                            w_restart    = 1'b1;
                            o_push.n     = 2'd1;
                            o_push.item0 = mk_result(KIND_INVALID, w_pos, '0, '0, 1'b1);
                        end
                    end
                    default: begin
                        n_mode = MODE_TEXT;
                    end
                endcase
            end
        end

        if (w_advance) begin
            n_position = r_position + PosW'(1);
        end
        if (w_restart) begin
            n_mode       = MODE_TEXT;
            n_position   = '0;
            n_lit_start  = '0;
            n_brace_pos  = '0;
            n_index      = '0;
            n_fmt_start  = '0;
            n_discarding = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cft_queue.sv
// short result queue between front and back: up to two pushes and one pop a cycle
// depends on cft_pkg
`default_nettype none

module cft_queue
    import cft_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_push    i_push,
    output logic          o_q_ready,
    output logic          o_q_valid,
    output t_result       o_head,
    input  wire logic     i_pop
);

    t_result          r_mem [QDepth];
    logic [QAw-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAw-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QAw:0]     r_count, n_count;
    logic             w_pop;
    logic [QAw-1:0]   w_wr_ptr1;

    assign o_q_ready = r_count <= (QAw+1)'(QDepth - 2);
    assign o_q_valid = r_count != '0;
    assign o_head    = r_mem[r_rd_ptr];
    assign w_pop     = i_pop && o_q_valid;
    assign w_wr_ptr1 = r_wr_ptr + QAw'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + QAw'(i_push.n);
        n_rd_ptr = r_rd_ptr + QAw'(w_pop);
        n_count  = r_count + (QAw+1)'(i_push.n) - (QAw+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.item1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cft_back.sv
// back part: output register that drives the result channel from the queue head
// depends on cft_pkg and cft_if
`default_nettype none

module cft_back
    import cft_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    input  wire t_result  i_head,
    output logic          o_pop,
    cft_result_if.source  o_result
);

    logic    r_valid, n_valid;
    t_result r_item;

    assign o_pop = i_q_valid && (!r_valid || o_result.ready);

    always_comb begin
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (o_result.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.kind        = r_item.kind;
    assign o_result.span_start  = r_item.span_start;
    assign o_result.span_length = r_item.span_length;
    assign o_result.arg_index   = r_item.arg_index;
    assign o_result.last        = r_item.last;

endmodule

`default_nettype wire
